// ===== rtl/wildcard_pattern_stream_matcher_defines.svh =====
// Assertion macros shared by the checker of the wildcard pattern stream matcher.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef WILDCARD_PATTERN_STREAM_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_STREAM_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wpsm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WPSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wpsm assertion failed");

`endif

// ===== rtl/wpsm_pkg.sv =====
// Package of the wildcard pattern stream matcher: sizes, register indexes and payload types.
// Used by wpsm_cell, the top level and the checker; depends on nothing.
package wpsm_pkg;

    localparam int MAX_NODES    = 8;
    localparam int POS_W        = 32;
    localparam int CELLS        = MAX_NODES + 1;
    localparam int NODE_IDX_W   = $clog2(CELLS);
    localparam int LIT_SLOTS    = 8;
    localparam int WILD_W       = 9;
    localparam int DELIM_SLOTS  = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int START_OUT_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES   = 3'd0,
        REG_WILD_MARKS      = 3'd1,
        REG_NODE_COUNT      = 3'd2,
        REG_DELIM_BYTES     = 3'd3,
        REG_DELIM_COUNT     = 3'd4
    } cfg_reg_t;

    localparam logic [63:0] DELIM_BYTES_RESET = 64'h2020202020202020;
    localparam logic [3:0]  DELIM_COUNT_RESET = 4'd1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       start_here;
    } feed_t;

    typedef struct packed {
        logic                   matched;
        logic [START_OUT_W-1:0] match_start;
    } result_t;

    typedef struct packed {
        logic             adv;
        logic [POS_W-1:0] start;
    } cell_link_t;

    typedef struct packed {
        logic       step;
        logic       clear;
        logic       delim;
        logic [7:0] data_byte;
    } cell_ctrl_t;

endpackage

// ===== rtl/wpsm_cell.sv =====
// One node cell of the matcher chain: holds the active flag and start position of one node.
// Depends on wpsm_pkg.
module wpsm_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wpsm_pkg::cell_ctrl_t                ctrl,
    input  logic [7:0]                          literal,
    input  logic                                wild,
    input  logic                                enabled,
    input  logic                                has_succ,
    input  logic                                seed,
    input  logic [wpsm_pkg::POS_W-1:0]          seed_start,
    input  wpsm_pkg::cell_link_t                prev,
    output wpsm_pkg::cell_link_t                link,
    output logic                                act_next,
    output logic [wpsm_pkg::POS_W-1:0]          start_next
);

    logic                         active_reg;
    logic [wpsm_pkg::POS_W-1:0]   start_reg;
    logic                         eff_act;
    logic [wpsm_pkg::POS_W-1:0]   eff_start;
    logic                         from_self;
    logic                         from_prev;

    assign eff_act   = active_reg | seed;
    assign eff_start = active_reg ? start_reg : seed_start;

    assign link.adv   = eff_act & has_succ & (literal == ctrl.data_byte);
    assign link.start = eff_start;

    assign from_self = eff_act & wild & ~ctrl.delim & enabled;
    assign from_prev = prev.adv & enabled;

    always_comb
    begin
        act_next = from_self | from_prev;
        if (from_self && from_prev)
        begin
            start_next = (eff_start < prev.start) ? eff_start : prev.start;
        end
        else if (from_self)
        begin
            start_next = eff_start;
        end
        else if (from_prev)
        begin
            start_next = prev.start;
        end
        else
        begin
            start_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            start_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            active_reg <= 1'b0;
            start_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            active_reg <= act_next;
            start_reg  <= start_next;
        end
    end

endmodule

// ===== rtl/wildcard_pattern_stream_matcher.sv =====
// An accepted request's result is registered into the main output register, or into the
// skid register while the main one holds an unread result. Throughput: one request per
// cycle while the skid register is empty, as every cell takes its neighbor's advance and
// start in the same cycle. A two-entry output stage lets a request enter while one result
// still waits. Reset (rst_n low) clears all cells, the byte position, the output stage and
// returns the configuration registers to their reset values.
module wildcard_pattern_stream_matcher (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [wpsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wpsm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               feed_valid,
    output logic                               feed_ready,
    input  wpsm_pkg::feed_t                    feed,
    output logic                               result_valid,
    input  logic                               result_ready,
    output wpsm_pkg::result_t                  result
);

    logic [63:0]                        pattern_reg;
    logic [wpsm_pkg::WILD_W-1:0]        wild_reg;
    logic [3:0]                         node_count_reg;
    logic [63:0]                        delim_bytes_reg;
    logic [3:0]                         delim_count_reg;
    logic [wpsm_pkg::POS_W-1:0]         pos_reg;

    logic                               accept;
    logic [wpsm_pkg::NODE_IDX_W-1:0]    n_eff;
    logic [3:0]                         delim_cnt_eff;
    logic                               delim_hit;
    wpsm_pkg::cell_ctrl_t               ctrl;
    wpsm_pkg::cell_link_t               links [wpsm_pkg::CELLS];
    logic                               act_nx [wpsm_pkg::CELLS];
    logic [wpsm_pkg::POS_W-1:0]         start_nx [wpsm_pkg::CELLS];
    wpsm_pkg::result_t                  new_res;

    wpsm_pkg::result_t                  main_reg;
    logic                               main_valid_reg;
    wpsm_pkg::result_t                  skid_reg;
    logic                               skid_valid_reg;
    logic                               pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            wild_reg        <= '0;
            node_count_reg  <= '0;
            delim_bytes_reg <= wpsm_pkg::DELIM_BYTES_RESET;
            delim_count_reg <= wpsm_pkg::DELIM_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wpsm_pkg::REG_PATTERN_BYTES: pattern_reg     <= cfg_data;
                wpsm_pkg::REG_WILD_MARKS:    wild_reg        <= cfg_data[wpsm_pkg::WILD_W-1:0];
                wpsm_pkg::REG_NODE_COUNT:    node_count_reg  <= cfg_data[3:0];
                wpsm_pkg::REG_DELIM_BYTES:   delim_bytes_reg <= cfg_data;
                wpsm_pkg::REG_DELIM_COUNT:   delim_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign feed_ready = ~skid_valid_reg;
    assign accept     = feed_valid & feed_ready;

    assign n_eff = (32'(node_count_reg) > wpsm_pkg::MAX_NODES) ?
                   wpsm_pkg::NODE_IDX_W'(wpsm_pkg::MAX_NODES) :
                   wpsm_pkg::NODE_IDX_W'(node_count_reg);

    assign delim_cnt_eff = (delim_count_reg > 4'(wpsm_pkg::DELIM_SLOTS)) ?
                           4'(wpsm_pkg::DELIM_SLOTS) : delim_count_reg;

    always_comb
    begin
        delim_hit = 1'b0;
        for (int k = 0; k < wpsm_pkg::DELIM_SLOTS; k++)
        begin
            if ((4'(k) < delim_cnt_eff) && (delim_bytes_reg[8*k +: 8] == feed.data_byte))
            begin
                delim_hit = 1'b1;
            end
        end
    end

    assign ctrl.step      = accept & ~feed.action;
    assign ctrl.clear     = accept & feed.action;
    assign ctrl.delim     = delim_hit;
    assign ctrl.data_byte = feed.data_byte;

    for (genvar j = 0; j < wpsm_pkg::CELLS; j++)
    begin : g_cell
        logic [7:0]           lit;
        logic                 wild;
        wpsm_pkg::cell_link_t prev;
        logic                 seed;

        if (j < wpsm_pkg::LIT_SLOTS)
        begin : g_lit
            assign lit = pattern_reg[8*j +: 8];
        end
        else
        begin : g_nolit
            assign lit = 8'd0;
        end

        if (j < wpsm_pkg::WILD_W)
        begin : g_wild
            assign wild = wild_reg[j];
        end
        else
        begin : g_nowild
            assign wild = 1'b0;
        end

        if (j == 0)
        begin : g_head
            assign prev = '0;
            assign seed = feed.start_here;
        end
        else
        begin : g_body
            assign prev = links[j-1];
            assign seed = 1'b0;
        end

        wpsm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .literal    (lit),
            .wild       (wild),
            .enabled    (wpsm_pkg::NODE_IDX_W'(j) <= n_eff),
            .has_succ   (wpsm_pkg::NODE_IDX_W'(j) < n_eff),
            .seed       (seed),
            .seed_start (pos_reg),
            .prev       (prev),
            .link       (links[j]),
            .act_next   (act_nx[j]),
            .start_next (start_nx[j])
        );
    end

    always_comb
    begin
        if (feed.action)
        begin
            new_res = '0;
        end
        else
        begin
            new_res.matched     = act_nx[n_eff];
            new_res.match_start = wpsm_pkg::START_OUT_W'(start_nx[n_eff]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            pos_reg <= '0;
        end
        else if (ctrl.step && (pos_reg != '1))
        begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    assign pop = main_valid_reg & result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_valid_reg && !pop)
        begin
            if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            main_valid_reg <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_valid_reg && !pop)
        begin
            if (accept)
            begin
                skid_reg <= new_res;
            end
        end
        else if (skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        else if (accept)
        begin
            main_reg <= new_res;
        end
    end

    assign result_valid = main_valid_reg;
    assign result       = main_reg;

endmodule

// ===== rtl/wpsm_checker.sv =====
// Port-level checker of the wildcard pattern stream matcher, bound to the top level.
// Depends on wpsm_pkg and wildcard_pattern_stream_matcher_defines.svh.
`include "wildcard_pattern_stream_matcher_defines.svh"

module wpsm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               feed_valid,
    input logic                               feed_ready,
    input wpsm_pkg::feed_t                    feed,
    input logic                               result_valid,
    input logic                               result_ready,
    input wpsm_pkg::result_t                  result
);

    `WPSM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
    `WPSM_ASSERT_NOW(a_nomatch_zero, result_valid && !result.matched, result.match_start == '0)
    `WPSM_ASSERT_NEXT(a_fill_output, feed_valid && feed_ready && !result_valid, result_valid)
    `WPSM_ASSERT_NEXT(a_clear_result, feed_valid && feed_ready && feed.action && !result_valid, !result.matched)
    `WPSM_ASSERT_NEXT(a_skid_full, feed_valid && feed_ready && result_valid && !result_ready, !feed_ready)

endmodule

bind wildcard_pattern_stream_matcher wpsm_checker u_wpsm_checker (.*);
